// ===== rtl/ipcc_pkg.sv =====
// ----------------------------------------------------------------------------
// ipcc_pkg: shared types and constants of the interrupt priority claim controller
// Holds the field widths, the item mode codes and the command and status
// structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package ipcc_pkg;

    // Default configuration of the top level
    localparam int NUM_SOURCES_DEF   = 256;
    localparam int PRIORITY_BITS_DEF = 3;

    // Fixed field widths
    localparam int ID_W  = 8;
    localparam int THR_W = 3;
    localparam int VAL_W = 3;

    // Kind of input word
    typedef enum logic [1:0] {
        MODE_EDGE     = 2'd0,
        MODE_COMPLETE = 2'd1,
        MODE_PRIORITY = 2'd2,
        MODE_ENABLE   = 2'd3
    } mode_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic clr_wr;      // clear the entry at the sweep counter
        logic capture;     // latch the accepted input word
        logic rd_item;     // read the entry of the latched source
        logic wr_item;     // update the entry of the latched source
        logic scan_start;  // reset the best candidate and the scan counter
        logic scan_rd;     // read the entry at the scan counter and advance
        logic finish;      // update claim and level, load the result word
    } ipcc_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic clr_last;    // sweep counter at the last entry
        logic need_scan;   // latched word asks for a rescan
        logic scan_last;   // scan counter at the last source
        logic out_free;    // result register can take a word this cycle
    } ipcc_status_t;

endpackage

// ===== rtl/ipcc_ram.sv =====
// ----------------------------------------------------------------------------
// ipcc_ram: generic single-port-write RAM with registered read
// One write and one read address per cycle; read data is registered and
// appears in the cycle after the read enable.
// ----------------------------------------------------------------------------
module ipcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/ipcc_ctrl.sv =====
// ----------------------------------------------------------------------------
// ipcc_ctrl: sequencer of the interrupt priority claim controller
// Runs the clearing sweep after reset, then for each input word a
// read-modify-write of the source entry, an optional rescan of all sources
// and the hand-off of the result word.
// ----------------------------------------------------------------------------
module ipcc_ctrl
    import ipcc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  ipcc_status_t status,
    output ipcc_cmd_t    cmd
);

    typedef enum logic [6:0] {
        ST_CLEAR  = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_READ   = 7'b0000100,
        ST_MODIFY = 7'b0001000,
        ST_SCAN   = 7'b0010000,
        ST_DRAIN  = 7'b0100000,
        ST_FINISH = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Take a word only when idle
    assign in_stall = (state_reg != ST_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (status.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.rd_item = 1'b1;
                state_next  = ST_MODIFY;
            end
            ST_MODIFY:
            begin
                cmd.wr_item = 1'b1;
                if (status.need_scan)
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/ipcc_datapath.sv =====
// ----------------------------------------------------------------------------
// ipcc_datapath: storage and scan logic of the interrupt priority claim controller
// Keeps pending, enable and priority of every source in one RAM, the
// threshold, the claim register and interrupt level, and the result register.
// ----------------------------------------------------------------------------
module ipcc_datapath
    import ipcc_pkg::*;
#(
    parameter int NUM_SOURCES   = NUM_SOURCES_DEF,
    parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [1:0]       mode,
    input  logic [ID_W-1:0]  source_id,
    input  logic [VAL_W-1:0] write_value,
    input  logic             priority_threshold_we,
    input  logic [THR_W-1:0] priority_threshold_wdata,
    input  logic             out_stall,
    output logic             out_valid,
    output logic [ID_W-1:0]  claim_id,
    output logic             core_irq,
    input  ipcc_cmd_t        cmd,
    output ipcc_status_t     status
);

    localparam int IDX_W   = $clog2(NUM_SOURCES);
    localparam int ENT_W   = PRIORITY_BITS + 2;
    localparam int CMP_W   = (PRIORITY_BITS > THR_W) ? PRIORITY_BITS : THR_W;
    localparam int IDX_X_W = (IDX_W > ID_W) ? IDX_W : ID_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SOURCES - 1);

    // Entry layout: pending, enable, priority
    localparam int PEND_BIT = ENT_W - 1;
    localparam int EN_BIT   = ENT_W - 2;

    logic [THR_W-1:0]         thr_reg, thr_next;
    mode_t                    mode_reg, mode_next;
    logic [ID_W-1:0]          id_reg, id_next;
    logic [VAL_W-1:0]         val_reg, val_next;
    logic [IDX_W-1:0]         clr_idx_reg, clr_idx_next;
    logic [IDX_W-1:0]         scan_idx_reg, scan_idx_next;
    logic                     eval_vld_reg, eval_vld_next;
    logic [IDX_W-1:0]         eval_id_reg, eval_id_next;
    logic [IDX_W-1:0]         best_id_reg, best_id_next;
    logic [PRIORITY_BITS-1:0] best_prio_reg, best_prio_next;
    logic                     scanned_reg, scanned_next;
    logic [ID_W-1:0]          claim_reg, claim_next;
    logic                     irq_reg, irq_next;
    logic                     out_valid_reg, out_valid_next;

    logic                     id_ok;
    logic [IDX_W-1:0]         id_idx;
    logic [IDX_X_W-1:0]       id_wide;
    logic [IDX_X_W-1:0]       best_wide;
    logic [CMP_W-1:0]         val_wide;
    logic [CMP_W-1:0]         prio_wide;
    logic [CMP_W-1:0]         thr_wide;
    logic [ENT_W-1:0]         rdata;
    logic [ENT_W-1:0]         ent_new;
    logic                     ent_we;
    logic                     hit;
    logic                     found;

    logic                     ram_we;
    logic [IDX_W-1:0]         ram_waddr;
    logic [ENT_W-1:0]         ram_wdata;
    logic                     ram_re;
    logic [IDX_W-1:0]         ram_raddr;

    // Source entry store
    ipcc_ram #(
        .WIDTH (ENT_W),
        .DEPTH (NUM_SOURCES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rdata)
    );

    // Decode the latched source id
    assign id_ok   = {{(32 - ID_W){1'b0}}, id_reg} < 32'(NUM_SOURCES);
    assign id_wide = IDX_X_W'(id_reg);
    assign id_idx  = id_wide[IDX_W-1:0];

    // Modify the entry of the latched source
    always_comb
    begin
        val_wide = CMP_W'(val_reg);
        ent_new  = rdata;
        ent_we   = 1'b0;
        case (mode_reg)
            MODE_EDGE:
            begin
                ent_new[PEND_BIT] = 1'b1;
                ent_we = id_ok && (id_reg != '0) && rdata[EN_BIT];
            end
            MODE_COMPLETE:
            begin
                ent_new[PEND_BIT] = 1'b0;
                ent_we = id_ok;
            end
            MODE_PRIORITY:
            begin
                ent_new[PRIORITY_BITS-1:0] = val_wide[PRIORITY_BITS-1:0];
                ent_we = id_ok;
            end
            MODE_ENABLE:
            begin
                ent_new[EN_BIT] = val_reg[0];
                ent_we = id_ok;
            end
            default:
            begin
                ent_we = 1'b0;
            end
        endcase
    end

    // Rescan after an accepted edge or any complete
    assign status.need_scan = (mode_reg == MODE_COMPLETE)
                           || ((mode_reg == MODE_EDGE) && ent_we);
    assign status.clr_last  = (clr_idx_reg == LAST_IDX);
    assign status.scan_last = (scan_idx_reg == LAST_IDX);
    assign status.out_free  = !out_valid_reg || !out_stall;

    // RAM port selection
    assign ram_we    = cmd.clr_wr || (cmd.wr_item && ent_we);
    assign ram_waddr = cmd.clr_wr ? clr_idx_reg : id_idx;
    assign ram_wdata = cmd.clr_wr ? '0 : ent_new;
    assign ram_re    = cmd.rd_item || cmd.scan_rd;
    assign ram_raddr = cmd.scan_rd ? scan_idx_reg : id_idx;

    // Candidate compare on the entry read in the previous cycle
    assign prio_wide = CMP_W'(rdata[PRIORITY_BITS-1:0]);
    assign thr_wide  = CMP_W'(thr_reg);
    assign hit       = eval_vld_reg && rdata[PEND_BIT] && (prio_wide > thr_wide)
                    && (rdata[PRIORITY_BITS-1:0] > best_prio_reg);
    assign found     = (best_id_reg != '0);
    assign best_wide = IDX_X_W'(best_id_reg);

    // Next values
    always_comb
    begin
        thr_next       = thr_reg;
        mode_next      = mode_reg;
        id_next        = id_reg;
        val_next       = val_reg;
        clr_idx_next   = clr_idx_reg;
        scan_idx_next  = scan_idx_reg;
        eval_vld_next  = cmd.scan_rd;
        eval_id_next   = scan_idx_reg;
        best_id_next   = best_id_reg;
        best_prio_next = best_prio_reg;
        scanned_next   = scanned_reg;
        claim_next     = claim_reg;
        irq_next       = irq_reg;
        out_valid_next = out_valid_reg && out_stall;

        if (priority_threshold_we)
        begin
            thr_next = priority_threshold_wdata;
        end
        if (cmd.clr_wr)
        begin
            clr_idx_next = clr_idx_reg + 1'b1;
        end
        if (cmd.capture)
        begin
            mode_next    = mode_t'(mode);
            id_next      = source_id;
            val_next     = write_value;
            scanned_next = 1'b0;
        end
        if (cmd.scan_start)
        begin
            scan_idx_next  = IDX_W'(1);
            best_id_next   = '0;
            best_prio_next = '0;
            scanned_next   = 1'b1;
        end
        if (cmd.scan_rd)
        begin
            scan_idx_next = scan_idx_reg + 1'b1;
        end
        if (hit)
        begin
            best_id_next   = eval_id_reg;
            best_prio_next = rdata[PRIORITY_BITS-1:0];
        end
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
            if (scanned_reg)
            begin
                if (found)
                begin
                    claim_next = best_wide[ID_W-1:0];
                    irq_next   = 1'b1;
                end
                else
                begin
                    claim_next = '0;
                    if (mode_reg == MODE_COMPLETE)
                    begin
                        irq_next = 1'b0;
                    end
                end
            end
        end
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg       <= '0;
            clr_idx_reg   <= '0;
            eval_vld_reg  <= 1'b0;
            scanned_reg   <= 1'b0;
            claim_reg     <= '0;
            irq_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            thr_reg       <= thr_next;
            clr_idx_reg   <= clr_idx_next;
            eval_vld_reg  <= eval_vld_next;
            scanned_reg   <= scanned_next;
            claim_reg     <= claim_next;
            irq_reg       <= irq_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        mode_reg      <= mode_next;
        id_reg        <= id_next;
        val_reg       <= val_next;
        scan_idx_reg  <= scan_idx_next;
        eval_id_reg   <= eval_id_next;
        best_id_reg   <= best_id_next;
        best_prio_reg <= best_prio_next;
    end

    assign out_valid = out_valid_reg;
    assign claim_id  = claim_reg;
    assign core_irq  = irq_reg;

endmodule

// ===== rtl/interrupt_priority_claim_controller.sv =====
// ----------------------------------------------------------------------------
// interrupt_priority_claim_controller: platform interrupt controller, one target
// Input words carry a source edge, a complete, a priority write or an enable
// write; every word returns one result word with claim id and irq level.
//
// Input channel: in_valid / in_stall with mode, source_id, write_value.
// Output channel: out_valid / out_stall with claim_id and core_irq.
// Threshold: priority_threshold_we with priority_threshold_wdata, write only.
//
// An edge on an enabled nonzero source or any complete rescans all sources in
// one RAM pass; other words update their entry without a rescan.
// The scan reads one source entry per cycle from the entry RAM.
// A result waits in the output register while out_stall is high; the next
// word is accepted meanwhile and holds before its own result until the
// register frees.
// After reset a sweep clears every entry of the entry RAM while
// in_stall stays high; threshold writes are taken during that sweep.
// ----------------------------------------------------------------------------
module interrupt_priority_claim_controller
    import ipcc_pkg::*;
#(
    parameter int NUM_SOURCES   = NUM_SOURCES_DEF,
    parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [1:0]       mode,
    input  logic [ID_W-1:0]  source_id,
    input  logic [VAL_W-1:0] write_value,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [ID_W-1:0]  claim_id,
    output logic             core_irq,
    input  logic             priority_threshold_we,
    input  logic [THR_W-1:0] priority_threshold_wdata
);

    ipcc_cmd_t    cmd;
    ipcc_status_t status;

    // Sequencer
    ipcc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Storage and scan
    ipcc_datapath #(
        .NUM_SOURCES   (NUM_SOURCES),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_datapath (
        .clk                      (clk),
        .rst_n                    (rst_n),
        .mode                     (mode),
        .source_id                (source_id),
        .write_value              (write_value),
        .priority_threshold_we    (priority_threshold_we),
        .priority_threshold_wdata (priority_threshold_wdata),
        .out_stall                (out_stall),
        .out_valid                (out_valid),
        .claim_id                 (claim_id),
        .core_irq                 (core_irq),
        .cmd                      (cmd),
        .status                   (status)
    );

    // One word at a time: busy right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted while a word is in progress");

    // A nonzero claim always comes with a raised interrupt
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (claim_id != '0) |-> core_irq)
        else $error("claim id set with interrupt low");

    // No result is loaded and no word is captured while the clearing sweep runs
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clr_wr |-> !cmd.finish && !cmd.capture)
        else $error("item activity during clearing sweep");

endmodule

// ===== sim/interrupt_priority_claim_controller_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// interrupt_priority_claim_controller_test: self-checking bench for the claim controller
// Drives edge, complete, priority and enable words through the valid/stall
// input channel and keeps a behavioral copy of the pending, enable and
// priority tables. Every accepted word yields one expected claim word, which is
// compared field by field with the word taken from the output channel.
// Phases run at several thresholds, with random idling on both sides, one
// stretch without idling and one long output hold-off that backs up the input.
// ----------------------------------------------------------------------------
module interrupt_priority_claim_controller_test;
    import ipcc_pkg::*;

    localparam int NUM_SRC   = NUM_SOURCES_DEF;
    localparam int IDLE_PCT  = 19;
    localparam int HOLD_LEN  = 3000;
    localparam int DRAIN_LEN = 300;
    localparam int LIMIT     = 1200000;

    typedef struct packed {
        mode_t            mode;
        logic [ID_W-1:0]  src;
        logic [VAL_W-1:0] val;
    } irq_word_t;

    typedef struct packed {
        logic [ID_W-1:0] claim;
        logic            irq;
    } claim_word_t;

    logic             clk;
    logic             rst_n                    = 1'b0;
    logic             in_valid                 = 1'b0;
    logic             in_stall;
    logic [1:0]       mode                     = MODE_EDGE;
    logic [ID_W-1:0]  source_id                = '0;
    logic [VAL_W-1:0] write_value              = '0;
    logic             out_valid;
    logic             out_stall                = 1'b0;
    logic [ID_W-1:0]  claim_id;
    logic             core_irq;
    logic             priority_threshold_we    = 1'b0;
    logic [THR_W-1:0] priority_threshold_wdata = '0;

    // Words waiting to be offered and claim words waiting to come back
    irq_word_t   word_plan_q[$];
    claim_word_t due_claims[$];

    // Behavioral copy of the controller state
    logic                   pend_tbl[NUM_SRC];
    logic                   en_tbl[NUM_SRC];
    logic [VAL_W-1:0]       prio_tbl[NUM_SRC];
    logic [ID_W-1:0]        claim_reg = '0;
    logic                   irq_reg   = 1'b0;
    logic [THR_W-1:0]       thr_model = '0;

    bit  in_took     = 1'b0;
    bit  steady      = 1'b0;
    bit  hold_go     = 1'b0;
    bit  hold_active = 1'b0;
    int  mismatch_count = 0;
    int  cycle_count    = 0;

    interrupt_priority_claim_controller u_dut (
        .clk                      (clk),
        .rst_n                    (rst_n),
        .in_valid                 (in_valid),
        .in_stall                 (in_stall),
        .mode                     (mode),
        .source_id                (source_id),
        .write_value              (write_value),
        .out_valid                (out_valid),
        .out_stall                (out_stall),
        .claim_id                 (claim_id),
        .core_irq                 (core_irq),
        .priority_threshold_we    (priority_threshold_we),
        .priority_threshold_wdata (priority_threshold_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Pick the pending source with the highest priority above threshold
    function automatic void find_winner();
        logic [ID_W-1:0]  best_id;
        logic [VAL_W-1:0] best_prio;
        best_id   = '0;
        best_prio = '0;
        for (int i = 1; i < NUM_SRC; i++)
        begin
            if (pend_tbl[i] && prio_tbl[i] > thr_model && prio_tbl[i] > best_prio)
            begin
                best_prio = prio_tbl[i];
                best_id   = ID_W'(i);
            end
        end
        claim_reg = best_id;
        if (best_id != '0)
            irq_reg = 1'b1;
    endfunction

    // Apply one accepted word to the state copy and return the claim word
    function automatic claim_word_t apply_word(irq_word_t w);
        claim_word_t r;
        case (w.mode)
            MODE_EDGE:
            begin
                if (w.src != '0 && en_tbl[w.src])
                begin
                    pend_tbl[w.src] = 1'b1;
                    find_winner();
                end
            end
            MODE_COMPLETE:
            begin
                pend_tbl[w.src] = 1'b0;
                irq_reg = 1'b0;
                find_winner();
            end
            MODE_PRIORITY: prio_tbl[w.src] = w.val;
            default:       en_tbl[w.src] = w.val[0];
        endcase
        r.claim = claim_reg;
        r.irq   = irq_reg;
        return r;
    endfunction

    // Queue one word
    function automatic void plan_word(mode_t m, logic [ID_W-1:0] s, logic [VAL_W-1:0] v);
        irq_word_t w;
        w.mode = m;
        w.src  = s;
        w.val  = v;
        word_plan_q.push_back(w);
    endfunction

    // Draw a source id, mostly from a small set so that edges and completes meet
    function automatic logic [ID_W-1:0] pick_source();
        int r;
        r = $urandom_range(99);
        if (r < 45)
            return ID_W'($urandom_range(12, 1));
        else if (r < 60)
            return ID_W'($urandom_range(255, 243));
        else if (r < 65)
            return '0;
        return ID_W'($urandom_range(255));
    endfunction

    // Fill the plan with n random words
    task automatic plan_random(int n);
        int    done;
        int    r;
        mode_t m;
        done = 0;
        while (done < n)
        begin
            r = $urandom_range(99);
            if (r < 40)
                m = MODE_EDGE;
            else if (r < 60)
                m = MODE_COMPLETE;
            else if (r < 80)
                m = MODE_PRIORITY;
            else
                m = MODE_ENABLE;
            plan_word(m, pick_source(), VAL_W'($urandom_range(7)));
            done++;
        end
    endtask

    // Hold until every planned word is accepted and every claim word is back
    task automatic wait_drained();
        while (word_plan_q.size() != 0 || due_claims.size() != 0 || in_valid)
            @(posedge clk);
    endtask

    // Write the threshold once every planned word is accepted and every claim word is back
    task automatic set_threshold(logic [THR_W-1:0] thr);
        wait_drained();
        @(negedge clk);
        priority_threshold_we    <= 1'b1;
        priority_threshold_wdata <= thr;
        thr_model = thr;
        @(negedge clk);
        priority_threshold_we <= 1'b0;
        @(posedge clk);
    endtask

    // Input side: advance to the next word once the current one is taken
    always @(negedge clk)
    begin : drive_in
        irq_word_t w;
        if (rst_n && (!in_valid || in_took))
        begin
            if (word_plan_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT))
            begin
                w = word_plan_q.pop_front();
                in_valid    <= 1'b1;
                mode        <= w.mode;
                source_id   <= w.src;
                write_value <= w.val;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Output side: random stall, forced high during the hold-off
    always @(negedge clk)
    begin
        if (rst_n)
            out_stall <= hold_active || (!steady && $urandom_range(99) < IDLE_PCT);
    end

    // Long hold-off on the output, timed here so the input keeps offering words
    initial
    begin
        wait (hold_go);
        @(posedge clk);
        hold_active = 1'b1;
        repeat (HOLD_LEN) @(posedge clk);
        hold_active = 1'b0;
    end

    // Check returned claim words, then predict for the word taken this edge
    always @(posedge clk)
    begin : watch
        claim_word_t exp_w;
        irq_word_t   got_w;
        in_took = 1'b0;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (due_claims.size() == 0)
                begin
                    $error("claim word with none expected: claim_id %0d core_irq %0d",
                           claim_id, core_irq);
                    mismatch_count++;
                end
                else
                begin
                    exp_w = due_claims.pop_front();
                    if (claim_id !== exp_w.claim)
                    begin
                        $error("claim_id: expected %0d, got %0d", exp_w.claim, claim_id);
                        mismatch_count++;
                    end
                    if (core_irq !== exp_w.irq)
                    begin
                        $error("core_irq: expected %0d, got %0d", exp_w.irq, core_irq);
                        mismatch_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                in_took = 1'b1;
                got_w.mode = mode_t'(mode);
                got_w.src  = source_id;
                got_w.val  = write_value;
                due_claims.push_back(apply_word(got_w));
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin : stimulus
        for (int i = 0; i < NUM_SRC; i++)
        begin
            pend_tbl[i] = 1'b0;
            en_tbl[i]   = 1'b0;
            prio_tbl[i] = '0;
        end
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: ignored edges, tie break, last source, complete corners
        set_threshold(3'd0);
        plan_word(MODE_EDGE,     8'd5,   3'b101);
        plan_word(MODE_EDGE,     8'd0,   3'b010);
        plan_word(MODE_ENABLE,   8'd255, 3'b111);
        plan_word(MODE_PRIORITY, 8'd255, 3'b111);
        plan_word(MODE_EDGE,     8'd255, 3'b000);
        plan_word(MODE_ENABLE,   8'd1,   3'b001);
        plan_word(MODE_PRIORITY, 8'd1,   3'b111);
        plan_word(MODE_EDGE,     8'd1,   3'b111);
        plan_word(MODE_EDGE,     8'd1,   3'b000);
        plan_word(MODE_PRIORITY, 8'd0,   3'b111);
        plan_word(MODE_ENABLE,   8'd0,   3'b001);
        plan_word(MODE_EDGE,     8'd0,   3'b000);
        plan_word(MODE_ENABLE,   8'd1,   3'b110);
        plan_word(MODE_COMPLETE, 8'd200, 3'b111);
        plan_word(MODE_COMPLETE, 8'd1,   3'b000);
        plan_word(MODE_COMPLETE, 8'd255, 3'b010);
        plan_word(MODE_ENABLE,   8'd20,  3'b001);
        plan_word(MODE_PRIORITY, 8'd20,  3'b100);
        plan_word(MODE_EDGE,     8'd20,  3'b000);
        plan_word(MODE_PRIORITY, 8'd20,  3'b000);
        plan_word(MODE_ENABLE,   8'd10,  3'b011);
        plan_word(MODE_EDGE,     8'd10,  3'b000);
        plan_word(MODE_COMPLETE, 8'd0,   3'b000);
        plan_word(MODE_COMPLETE, 8'd10,  3'b000);
        plan_word(MODE_COMPLETE, 8'd20,  3'b000);

        // Random phases at several thresholds; the first backs up behind a hold-off
        set_threshold(3'd3);
        hold_go = 1'b1;
        plan_random(250);

        set_threshold(3'd0);
        steady = 1'b1;
        plan_random(200);

        set_threshold(3'd7);
        steady = 1'b0;
        plan_random(100);

        set_threshold(3'd1);
        plan_random(200);

        set_threshold(3'd5);
        plan_random(150);

        wait_drained();
        repeat (DRAIN_LEN) @(posedge clk);
        if (mismatch_count == 0 && due_claims.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/ipcc_pkg.sv
rtl/ipcc_ram.sv
rtl/ipcc_ctrl.sv
rtl/ipcc_datapath.sv
rtl/interrupt_priority_claim_controller.sv
sim/interrupt_priority_claim_controller_test.sv
